[hdl/rsck_pkg.sv]
// package: record types, sort rank and control types for the composite-key record sorter
`default_nettype none
package rsck_pkg;

  localparam int unsigned MAX_RECORDS = 64;
  localparam int unsigned RANK_W = 30;

  typedef struct packed {
    logic [6:0]  eng_mark;
    logic [6:0]  math_mark;
    logic [15:0] student_id;
    logic [5:0]  tag;
    logic        last_in;
  } in_item_t;

  typedef struct packed {
    logic [6:0]  out_eng_mark;
    logic [6:0]  out_math_mark;
    logic [15:0] out_student_id;
    logic [5:0]  out_tag;
    logic        last_out;
    logic        overflow;
  } out_item_t;

  typedef struct packed {
    logic [6:0]  eng_mark;
    logic [6:0]  math_mark;
    logic [15:0] student_id;
    logic [5:0]  tag;
  } record_t;

  typedef struct packed {
    logic load;
    logic drain;
  } chain_ctl_t;

  typedef enum logic {
    ST_LOAD,
    ST_DRAIN
  } sort_state_t;

  // larger rank leaves first
  function automatic logic [RANK_W-1:0] rank_of(input record_t r);
    rank_of = {r.eng_mark, r.math_mark, ~r.student_id};
  endfunction

endpackage
`default_nettype wire

[hdl/rsck_cell.sv]
// one cell of the insertion chain: holds a record and its valid bit
`default_nettype none
module rsck_cell (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire rsck_pkg::chain_ctl_t ctl,
  input  wire rsck_pkg::record_t   new_rec,
  input  wire rsck_pkg::record_t   prev_rec,
  input  wire logic                prev_vld,
  input  wire logic                prev_ins,
  input  wire rsck_pkg::record_t   next_rec,
  input  wire logic                next_vld,
  output rsck_pkg::record_t        rec,
  output logic                     vld,
  output logic                     ins
);
  import rsck_pkg::*;

  // new record lands at or before this cell
  assign ins = vld ? (rank_of(new_rec) > rank_of(rec)) : 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (ctl.load && ins) begin
      vld <= prev_ins ? prev_vld : 1'b1;
    end else if (ctl.drain) begin
      vld <= next_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load && ins) begin
      rec <= prev_ins ? prev_rec : new_rec;
    end else if (ctl.drain) begin
      rec <= next_rec;
    end
  end

endmodule
`default_nettype wire

[hdl/record_sorter_composite_key_core.sv]
// top level: insertion chain record sorter with drain control and result register
//
// channel | handshake            | payload
// rec     | rec_valid, rec_ready | rec (in_item_t)
// res     | res_valid, res_ready | res (out_item_t)
//
// loading takes one record per cycle; each chain cell compares the new record in parallel
// after the record flagged last, the chain shifts one record per cycle into the result register
// whenever res_valid is low or res_ready is high; rec_ready is low meanwhile
// reset clears the cell valid bits, the state, the drop flag and res_valid; no clearing pass
// a stalled result holds the drain; records beyond MAX_RECORDS are dropped and flagged
`default_nettype none
module record_sorter_composite_key_core (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               rec_valid,
  output logic                    rec_ready,
  input  wire rsck_pkg::in_item_t rec,
  output logic                    res_valid,
  input  wire logic               res_ready,
  output rsck_pkg::out_item_t     res
);
  import rsck_pkg::*;

  sort_state_t state, state_next;
  logic        dropped, dropped_next;
  chain_ctl_t  ctl;
  record_t     new_rec;
  record_t     cell_rec [MAX_RECORDS];
  logic        cell_vld [MAX_RECORDS];
  logic        cell_ins [MAX_RECORDS];
  logic        xfer, full, shift;

  assign new_rec = '{eng_mark: rec.eng_mark, math_mark: rec.math_mark,
                     student_id: rec.student_id, tag: rec.tag};
  assign full    = cell_vld[MAX_RECORDS-1];

  genvar i;
  generate
    for (i = 0; i < MAX_RECORDS; i++) begin : g_cell
      if (i == 0) begin : g_head
        rsck_cell u_cell (
          .clk      (clk),
          .rst      (rst),
          .ctl      (ctl),
          .new_rec  (new_rec),
          .prev_rec (new_rec),
          .prev_vld (1'b0),
          .prev_ins (1'b0),
          .next_rec (cell_rec[1]),
          .next_vld (cell_vld[1]),
          .rec      (cell_rec[0]),
          .vld      (cell_vld[0]),
          .ins      (cell_ins[0])
        );
      end else if (i == MAX_RECORDS - 1) begin : g_tail
        rsck_cell u_cell (
          .clk      (clk),
          .rst      (rst),
          .ctl      (ctl),
          .new_rec  (new_rec),
          .prev_rec (cell_rec[i-1]),
          .prev_vld (cell_vld[i-1]),
          .prev_ins (cell_ins[i-1]),
          .next_rec ('0),
          .next_vld (1'b0),
          .rec      (cell_rec[i]),
          .vld      (cell_vld[i]),
          .ins      (cell_ins[i])
        );
      end else begin : g_mid
        rsck_cell u_cell (
          .clk      (clk),
          .rst      (rst),
          .ctl      (ctl),
          .new_rec  (new_rec),
          .prev_rec (cell_rec[i-1]),
          .prev_vld (cell_vld[i-1]),
          .prev_ins (cell_ins[i-1]),
          .next_rec (cell_rec[i+1]),
          .next_vld (cell_vld[i+1]),
          .rec      (cell_rec[i]),
          .vld      (cell_vld[i]),
          .ins      (cell_ins[i])
        );
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_LOAD;
      dropped <= 1'b0;
    end else begin
      state   <= state_next;
      dropped <= dropped_next;
    end
  end

  always_comb begin
    state_next   = state;
    dropped_next = dropped;
    rec_ready    = 1'b0;
    xfer         = 1'b0;
    shift        = 1'b0;
    ctl          = '0;
    unique case (state)
      ST_LOAD: begin
        rec_ready = 1'b1;
        xfer      = rec_valid;
        ctl.load  = xfer && !full;
        if (xfer && full) begin
          dropped_next = 1'b1;
        end
        if (xfer && rec.last_in) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        shift     = !res_valid || res_ready;
        ctl.drain = shift;
        if (shift && !cell_vld[1]) begin
          state_next   = ST_LOAD;
          dropped_next = 1'b0;
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (shift) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      res <= '{out_eng_mark: cell_rec[0].eng_mark, out_math_mark: cell_rec[0].math_mark,
               out_student_id: cell_rec[0].student_id, out_tag: cell_rec[0].tag,
               last_out: !cell_vld[1], overflow: dropped};
    end
  end

`ifndef SYNTHESIS
  a_drain_has_head: assert property (@(posedge clk) disable iff (rst)
    state == ST_DRAIN |-> cell_vld[0])
    else $error("drain with empty head cell");

  a_head_order: assert property (@(posedge clk) disable iff (rst)
    cell_vld[0] && cell_vld[1] |-> rank_of(cell_rec[0]) >= rank_of(cell_rec[1]))
    else $error("chain head out of order");

  a_last_starts_drain: assert property (@(posedge clk) disable iff (rst)
    rec_valid && rec_ready && rec.last_in |=> state == ST_DRAIN)
    else $error("last record did not start drain");

  a_drain_empties: assert property (@(posedge clk) disable iff (rst)
    shift && !cell_vld[1] |=> !cell_vld[0] && !dropped)
    else $error("chain not empty after final transfer");
`endif

endmodule
`default_nettype wire
